FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL files (included by swk_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check that is disabled while reset is asserted.
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication check that is disabled while reset is asserted.
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/core/swk_pkg.sv
// ----------------------------------------------------------------------------
// Swerve kinematics package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package swk_pkg;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_DB = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_DB = 2'd3;
	localparam logic [1:0] MODE_CHASSIS = 2'd0;
	localparam logic [1:0] MODE_GLOBAL = 2'd1;
	localparam logic [1:0] MODE_LOCKED = 2'd2;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	localparam int CW = 40;
	localparam logic signed [CW-1:0] PI_Q30 = 40'sd3373259426;
	localparam logic signed [CW-1:0] HALF_PI_Q30 = 40'sd1686629713;
	localparam logic signed [CW-1:0] GAIN_Q30 = 40'sd652032874;
	localparam logic signed [31:0] DEG90 = 32'sd23040;
	localparam logic signed [31:0] DEG180 = 32'sd46080;
	localparam logic signed [31:0] DEG360 = 32'sd92160;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROT_CORDIC, ST_ROT_MUL, ST_ROT_SUM, ST_CHECK, ST_VN_MUL, ST_T_MUL,
		ST_WHEEL_INIT, ST_VEC_ITER, ST_MAG_MUL, ST_DEG_MUL, ST_WRAP, ST_APPLY, ST_OUT
	} swk_state_t;

	typedef struct packed {
		logic load;
		logic rot_start;
		logic rot_iter;
		logic rot_mul;
		logic rot_sum;
		logic check;
		logic vn_mul;
		logic t_mul;
		logic wheel_init;
		logic vec_iter;
		logic mag_mul;
		logic deg_mul;
		logic wrap;
		logic apply;
		logic out_load;
	} swk_cmd_t;

	typedef struct packed {
		logic is_global;
		logic stop;
		logic iter_last;
		logic wheel_last;
	} swk_sts_t;

	function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
		logic signed [CW-1:0] r;
		unique case (i)
			5'd0: r = 40'sd843314857;
			5'd1: r = 40'sd497837829;
			5'd2: r = 40'sd263043837;
			5'd3: r = 40'sd133525159;
			5'd4: r = 40'sd67021687;
			5'd5: r = 40'sd33543516;
			5'd6: r = 40'sd16775851;
			5'd7: r = 40'sd8388437;
			5'd8: r = 40'sd4194283;
			5'd9: r = 40'sd2097149;
			default: r = 40'sd1 <<< (5'd30 - i);
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] wrap180(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = v;
		if (r > 34'(DEG180))
			r = r - 34'(DEG360);
		if (r <= -34'(DEG180))
			r = r + 34'(DEG360);
		return r[31:0];
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/swk_ctrl.sv
// ----------------------------------------------------------------------------
// Swerve kinematics controller
// Sequences the global-mode rotation, deadband check and four per-wheel CORDIC passes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module swk_ctrl
	import swk_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire swk_sts_t sts,
	output swk_cmd_t      cmd
);
	swk_state_t state_q, state_nx;
	logic out_valid_q, out_valid_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			out_valid_q <= out_valid_nx;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid_nx = out_valid_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_ROT_CORDIC;
				end
			end
			ST_ROT_CORDIC: begin
				if (sts.is_global) begin
					cmd.rot_iter = 1'b1;
					if (sts.iter_last)
						state_nx = ST_ROT_MUL;
				end else begin
					cmd.rot_sum = 1'b1;
					state_nx = ST_CHECK;
				end
			end
			ST_ROT_MUL: begin
				cmd.rot_mul = 1'b1;
				state_nx = ST_ROT_SUM;
			end
			ST_ROT_SUM: begin
				cmd.rot_sum = 1'b1;
				state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_nx = ST_VN_MUL;
			end
			ST_VN_MUL: begin
				if (sts.stop)
					state_nx = ST_OUT;
				else begin
					cmd.vn_mul = 1'b1;
					state_nx = ST_T_MUL;
				end
			end
			ST_T_MUL: begin
				cmd.t_mul = 1'b1;
				state_nx = ST_WHEEL_INIT;
			end
			ST_WHEEL_INIT: begin
				cmd.wheel_init = 1'b1;
				state_nx = ST_VEC_ITER;
			end
			ST_VEC_ITER: begin
				cmd.vec_iter = 1'b1;
				if (sts.iter_last)
					state_nx = ST_MAG_MUL;
			end
			ST_MAG_MUL: begin
				cmd.mag_mul = 1'b1;
				state_nx = ST_DEG_MUL;
			end
			ST_DEG_MUL: begin
				cmd.deg_mul = 1'b1;
				state_nx = ST_WRAP;
			end
			ST_WRAP: begin
				cmd.wrap = 1'b1;
				state_nx = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_nx = sts.wheel_last ? ST_OUT : ST_WHEEL_INIT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					out_valid_nx = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	`ASSERT_IMP(a_load_idle, cmd.load, state_q == ST_IDLE)
	`ASSERT_NXT(a_out_valid, cmd.out_load, out_valid)
	`ASSERT_IMP(a_busy_stall, state_q != ST_IDLE, in_stall)
endmodule
`default_nettype wire

FILE: rtl/core/swk_datapath.sv
// ----------------------------------------------------------------------------
// Swerve kinematics datapath
// Shared CORDIC, multipliers, wheel angle state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module swk_datapath
	import swk_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire swk_cmd_t            cmd,
	output swk_sts_t                 sts,
	input  wire logic                cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic signed [23:0]  vel_x,
	input  wire logic signed [23:0]  vel_y,
	input  wire logic signed [23:0]  yaw_rate,
	input  wire logic signed [18:0]  heading,
	output logic signed [23:0]       speed_1,
	output logic signed [23:0]       speed_2,
	output logic signed [23:0]       speed_3,
	output logic signed [23:0]       speed_4,
	output logic signed [31:0]       angle_1,
	output logic signed [31:0]       angle_2,
	output logic signed [31:0]       angle_3,
	output logic signed [31:0]       angle_4,
	output logic                     stopped
);
	localparam int IW = $clog2(CORDIC_STEPS);

	logic [1:0] frame_mode_q;
	logic [19:0] radius_q;
	logic [15:0] lin_db_q, rot_db_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= MODE_GLOBAL;
			radius_q <= 20'd26214;
			lin_db_q <= 16'd66;
			rot_db_q <= 16'd26;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_MODE: frame_mode_q <= cfg_data[1:0];
				REG_RADIUS: radius_q <= cfg_data;
				REG_LIN_DB: lin_db_q <= cfg_data[15:0];
				REG_ROT_DB: rot_db_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic signed [23:0] vx_q, vy_q, wz_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic neg_q, stop_q, is_global, zvec_q;
	logic [IW-1:0] it_q;
	logic [1:0] wk_q;
	logic signed [63:0] p1_q, p2_q, p3_q, p4_q, np_q;
	logic signed [24:0] rx_q, ry_q;
	logic signed [31:0] t_q;
	logic signed [31:0] wheel_angle_q [4];
	logic signed [23:0] spd_q [4];
	logic signed [24:0] mag_q;
	logic signed [31:0] dir_q, err_q, now_q;

	assign is_global = (frame_mode_q == MODE_GLOBAL);
	assign sts.is_global = is_global;
	assign sts.stop = stop_q;
	assign sts.iter_last = (it_q == IW'(CORDIC_STEPS - 1));
	assign sts.wheel_last = (wk_q == 2'd3);

	logic signed [CW-1:0] z0, dx, dy, atn;
	logic rot_dir;
	assign z0 = CW'(heading) <<< 14;
	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign atn = atan_q30(5'(it_q));
	assign rot_dir = cmd.vec_iter ? !y_q[CW-1] : !z_q[CW-1];

	logic signed [CW-1:0] cs_c, cs_s;
	assign cs_c = neg_q ? -x_q : x_q;
	assign cs_s = neg_q ? -y_q : y_q;

	logic signed [31:0] wx, wy;
	logic signed [24:0] rx_l, ry_l;
	logic signed [63:0] sx, sy;
	logic [24:0] arx, ary, awz;
	assign wx = 32'(rx_q) + ((wk_q == 2'd0 || wk_q == 2'd3) ? -t_q : t_q);
	assign wy = 32'(ry_q) + ((wk_q == 2'd0 || wk_q == 2'd1) ? -t_q : t_q);
	assign sx = (p1_q + p2_q) >>> 30;
	assign sy = (p3_q - p4_q) >>> 30;
	assign rx_l = is_global ? sx[24:0] : (frame_mode_q == MODE_CHASSIS ? 25'(vx_q) : '0);
	assign ry_l = is_global ? sy[24:0] : (frame_mode_q == MODE_CHASSIS ? 25'(vy_q) : '0);
	assign arx = rx_q[24] ? 25'(-rx_q) : 25'(rx_q);
	assign ary = ry_q[24] ? 25'(-ry_q) : 25'(ry_q);
	assign awz = wz_q[23] ? 25'(-25'(wz_q)) : 25'(wz_q);

	// The stored angle is folded to one turn with a reciprocal of 360 degrees
	// (2^48 / 92160); the remainder then lies in 0 to 360 degrees.
	logic signed [33:0] now_r, err_w, dsum;
	logic signed [31:0] err_f;
	logic signed [24:0] spd_c;
	logic signed [63:0] dm, nq;
	assign dm = (p1_q + 64'sd137438953472) >>> 38;
	assign nq = np_q >>> 48;
	assign now_r = 34'(wheel_angle_q[wk_q]) - 34'(nq) * 34'sd92160;
	assign err_w = 34'(dir_q) - 34'(now_q);
	assign spd_c = (mag_q > 25'sd8388607) ? 25'sd8388607 : mag_q;
	always_comb begin
		err_f = err_q;
		if (err_q > DEG90 || err_q < -DEG90) begin
			err_f = err_q[31] ? err_q + DEG180 : err_q - DEG180;
		end
	end
	assign dsum = 34'($signed(dm[31:0])) - 34'(DEG90);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++)
				wheel_angle_q[k] <= '0;
			it_q <= '0;
			wk_q <= '0;
			stop_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				vx_q <= vel_x;
				vy_q <= vel_y;
				wz_q <= yaw_rate;
				it_q <= '0;
				wk_q <= '0;
				x_q <= GAIN_Q30;
				y_q <= '0;
				neg_q <= 1'b0;
				if (z0 > HALF_PI_Q30) begin
					z_q <= z0 - PI_Q30;
					neg_q <= 1'b1;
				end else if (z0 < -HALF_PI_Q30) begin
					z_q <= z0 + PI_Q30;
					neg_q <= 1'b1;
				end else
					z_q <= z0;
			end
			if (cmd.rot_iter || cmd.vec_iter) begin
				it_q <= sts.iter_last ? '0 : it_q + 1'b1;
				if (rot_dir) begin
					x_q <= x_q + (cmd.vec_iter ? dx : -dx);
					y_q <= y_q + (cmd.vec_iter ? -dy : dy);
					z_q <= z_q + (cmd.vec_iter ? atn : -atn);
				end else begin
					x_q <= x_q + (cmd.vec_iter ? -dx : dx);
					y_q <= y_q + (cmd.vec_iter ? dy : -dy);
					z_q <= z_q + (cmd.vec_iter ? -atn : atn);
				end
			end
			if (cmd.rot_mul) begin
				p1_q <= 64'(vx_q) * 64'(cs_c);
				p2_q <= 64'(vy_q) * 64'(cs_s);
				p3_q <= 64'(vy_q) * 64'(cs_c);
				p4_q <= 64'(vx_q) * 64'(cs_s);
			end
			if (cmd.rot_sum) begin
				rx_q <= rx_l;
				ry_q <= ry_l;
			end
			if (cmd.check) begin
				stop_q <= arx <= 25'(lin_db_q) && ary <= 25'(lin_db_q) &&
					awz <= 25'(rot_db_q);
				p2_q <= 64'(wz_q) * 64'($signed({1'b0, radius_q}));
			end
			if (cmd.vn_mul)
				p1_q <= (p2_q * 64'sd292818) >>> 32;
			if (cmd.t_mul) begin
				p2_q <= p1_q * 64'sd759250125;
				t_q <= 32'((p1_q * 64'sd759250125) >>> 30);
			end
			if (cmd.wheel_init) begin
				it_q <= '0;
				zvec_q <= (wx == 0 && wy == 0);
				if (wx == 0 && wy == 0) begin
					x_q <= '0;
					y_q <= '0;
					z_q <= '0;
				end else if (wx[31]) begin
					x_q <= -CW'(wx);
					y_q <= -CW'(wy);
					z_q <= wy[31] ? -PI_Q30 : PI_Q30;
				end else begin
					x_q <= CW'(wx);
					y_q <= CW'(wy);
					z_q <= '0;
				end
			end
			if (cmd.mag_mul) begin
				p2_q <= (64'(x_q) * 64'(GAIN_Q30)) >>> 30;
				p1_q <= zvec_q ? '0 : 64'(z_q) * 64'sd3754936;
				np_q <= 64'(wheel_angle_q[wk_q]) * 64'sd3054198966;
			end
			if (cmd.deg_mul) begin
				mag_q <= (p2_q > 64'sd8388607) ? 25'sd8388607 : p2_q[24:0];
				dir_q <= wrap180(dsum);
				now_q <= (now_r > 34'(DEG180)) ? 32'(now_r - 34'(DEG360)) : 32'(now_r);
			end
			if (cmd.wrap)
				err_q <= wrap180(err_w);
			if (cmd.apply) begin
				spd_q[wk_q] <= (err_q > DEG90 || err_q < -DEG90) ?
					24'(-spd_c) : 24'(spd_c);
				wheel_angle_q[wk_q] <= wheel_angle_q[wk_q] + err_f;
				wk_q <= wk_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			stopped <= stop_q;
			speed_1 <= stop_q ? '0 : spd_q[0];
			speed_2 <= stop_q ? '0 : spd_q[1];
			speed_3 <= stop_q ? '0 : spd_q[2];
			speed_4 <= stop_q ? '0 : spd_q[3];
			angle_1 <= wheel_angle_q[0];
			angle_2 <= wheel_angle_q[1];
			angle_3 <= wheel_angle_q[2];
			angle_4 <= wheel_angle_q[3];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/swerve_drive_wheel_kinematics_core.sv
// ----------------------------------------------------------------------------
// Swerve drive wheel kinematics core
// Four-wheel inverse kinematics with shortest-arc steering.
// ----------------------------------------------------------------------------
// One request at a time, paced by the single shared CORDIC unit. In global frame
// mode a request runs through the heading rotation, the deadband check and the
// rotation term, then a CORDIC pass for each of the four wheels, then loads the
// result and returns to idle before the next request is accepted. Chassis and
// locked modes skip the heading rotation. A deadband stop ends after the check.
// A stalled result holds the block until it is taken.
`default_nettype none
module swerve_drive_wheel_kinematics_core
	import swk_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic signed [23:0]    vel_x,
	input  wire logic signed [23:0]    vel_y,
	input  wire logic signed [23:0]    yaw_rate,
	input  wire logic signed [18:0]    heading,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [23:0]         speed_1,
	output logic signed [23:0]         speed_2,
	output logic signed [23:0]         speed_3,
	output logic signed [23:0]         speed_4,
	output logic signed [31:0]         angle_1,
	output logic signed [31:0]         angle_2,
	output logic signed [31:0]         angle_3,
	output logic signed [31:0]         angle_4,
	output logic                       stopped
);
	swk_cmd_t cmd;
	swk_sts_t sts;

	swk_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	swk_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.vel_x(vel_x), .vel_y(vel_y), .yaw_rate(yaw_rate), .heading(heading),
		.speed_1(speed_1), .speed_2(speed_2), .speed_3(speed_3), .speed_4(speed_4),
		.angle_1(angle_1), .angle_2(angle_2), .angle_3(angle_3), .angle_4(angle_4),
		.stopped(stopped)
	);
endmodule
`default_nettype wire
